// ===== design/tffs_pkg.sv =====
// ----------------------------------------------------------------------------
// tffs_pkg
// shared constants, widths and controller/datapath link types for the
// trilinear force field sampler
// ----------------------------------------------------------------------------
package tffs_pkg;

    localparam int MAX_GRID    = 16;
    localparam int STORE_DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(MAX_GRID);
    localparam int R_W         = $clog2(MAX_GRID + 1);
    localparam int RR_W        = 2 * R_W;
    localparam int M_W         = (IDX_W > 3) ? IDX_W : 3;

    localparam int RES_W       = 5;
    localparam int ENTRY_W     = 12;
    localparam int POS_W       = 24;
    localparam int FORCE_W     = 32;
    localparam int AXES        = 3;

    localparam int FRAC_BITS   = 18;
    localparam int W_W         = FRAC_BITS + 1;
    localparam int PW_W        = 2 * W_W;
    localparam int PE_W        = POS_W + 1;
    localparam int T_W         = PE_W + M_W + 1;
    localparam int Q_W         = T_W - FRAC_BITS;
    localparam int PROD_W      = FORCE_W + W_W + 1;
    localparam int ACC_W       = PROD_W + 3;
    localparam int TWO_Q16     = 2 << 16;

    localparam int CORNERS     = 8;
    localparam int CNT_W       = 3;
    localparam int PIPE_DRAIN  = 5;

    localparam logic [W_W-1:0] W_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic             write_entry;
        logic             capture;
        logic             setup;
        logic             clear_acc;
        logic             issue;
        logic [CNT_W-1:0] corner;
        logic             load_out;
        logic             out_zero;
    } tffs_cmd_t;

    typedef struct packed {
        logic in_range;
        logic res_zero;
    } tffs_sts_t;

endpackage

// ===== design/tffs_if.sv =====
// ----------------------------------------------------------------------------
// tffs_if
// handshake channels of the sampler: request items, result items and the
// resolution register write channel
// ----------------------------------------------------------------------------
interface tffs_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic        [tffs_pkg::ENTRY_W-1:0]   entry_index;
    logic signed [tffs_pkg::FORCE_W-1:0]   load_fx;
    logic signed [tffs_pkg::FORCE_W-1:0]   load_fy;
    logic signed [tffs_pkg::FORCE_W-1:0]   load_fz;
    logic signed [tffs_pkg::POS_W-1:0]     pos_x;
    logic signed [tffs_pkg::POS_W-1:0]     pos_y;
    logic signed [tffs_pkg::POS_W-1:0]     pos_z;

    modport source (output valid, kind, entry_index, load_fx, load_fy, load_fz,
                    pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, kind, entry_index, load_fx, load_fy, load_fz,
                    pos_x, pos_y, pos_z, output ready);
endinterface

interface tffs_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tffs_pkg::FORCE_W-1:0]   out_fx;
    logic signed [tffs_pkg::FORCE_W-1:0]   out_fy;
    logic signed [tffs_pkg::FORCE_W-1:0]   out_fz;
    logic                                  in_grid;

    modport source (output valid, out_fx, out_fy, out_fz, in_grid, input ready);
    modport sink   (input valid, out_fx, out_fy, out_fz, in_grid, output ready);
endinterface

interface tffs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tffs_pkg::RES_W-1:0]      grid_resolution;

    modport source (output valid, grid_resolution, input ready);
    modport sink   (input valid, grid_resolution, output ready);
endinterface

// ===== design/tffs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tffs_ctrl
// sequencer for one sample: cell setup, eight corner issues, pipeline drain
// and hand-off into the result register
// ----------------------------------------------------------------------------
module tffs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_kind,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tffs_pkg::tffs_sts_t sts,
    output tffs_pkg::tffs_cmd_t cmd
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [ST_W-1:0] ST_SETUP  = 3'd1;
    localparam logic [ST_W-1:0] ST_DECIDE = 3'd2;
    localparam logic [ST_W-1:0] ST_ISSUE  = 3'd3;
    localparam logic [ST_W-1:0] ST_DRAIN  = 3'd4;
    localparam logic [ST_W-1:0] ST_FINISH = 3'd5;

    logic [ST_W-1:0]            state_reg, state_next;
    logic [tffs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       zero_reg, zero_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       accept;
    logic                       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd             = '0;
        cmd.write_entry = accept && (in_kind == tffs_pkg::KIND_LOAD);
        cmd.capture     = accept && (in_kind == tffs_pkg::KIND_SAMPLE);
        cmd.setup       = (state_reg == ST_SETUP);
        cmd.clear_acc   = (state_reg == ST_DECIDE);
        cmd.issue       = (state_reg == ST_ISSUE);
        cmd.corner      = cnt_reg;
        cmd.load_out    = (state_reg == ST_FINISH) && slot_free;
        cmd.out_zero    = zero_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        zero_next  = zero_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                zero_next = sts.res_zero || !sts.in_range;
                cnt_next  = '0;
                if (sts.res_zero || !sts.in_range)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (cnt_reg == tffs_pkg::CNT_W'(tffs_pkg::CORNERS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == tffs_pkg::CNT_W'(tffs_pkg::PIPE_DRAIN - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // all eight corners go out before the drain starts
    a_full_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && $past(state_reg) == ST_ISSUE)
        |-> $past(cnt_reg) == tffs_pkg::CNT_W'(tffs_pkg::CORNERS - 1))
        else $error("drain entered before all corners were issued");

    a_sample_setup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_SETUP)
        else $error("sample item not followed by setup");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.load_out)
        else $error("result register overwritten while still held");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside the finish step");

endmodule

// ===== design/tffs_dp.sv =====
// ----------------------------------------------------------------------------
// tffs_dp
// datapath: resolution register, grid memory, cell and fraction setup,
// corner weight and force product pipeline, accumulators and result register
// ----------------------------------------------------------------------------
module tffs_dp
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic        [tffs_pkg::RES_W-1:0]      cfg_res,
    input  logic        [tffs_pkg::ENTRY_W-1:0]    entry_index,
    input  logic signed [tffs_pkg::FORCE_W-1:0]    load_fx,
    input  logic signed [tffs_pkg::FORCE_W-1:0]    load_fy,
    input  logic signed [tffs_pkg::FORCE_W-1:0]    load_fz,
    input  logic signed [tffs_pkg::POS_W-1:0]      pos_x,
    input  logic signed [tffs_pkg::POS_W-1:0]      pos_y,
    input  logic signed [tffs_pkg::POS_W-1:0]      pos_z,
    input  tffs_pkg::tffs_cmd_t                    cmd,
    output tffs_pkg::tffs_sts_t                    sts,
    output logic signed [tffs_pkg::FORCE_W-1:0]    out_fx,
    output logic signed [tffs_pkg::FORCE_W-1:0]    out_fy,
    output logic signed [tffs_pkg::FORCE_W-1:0]    out_fz,
    output logic                                   in_grid
);

    localparam int WORD_W = tffs_pkg::AXES * tffs_pkg::FORCE_W;

    // configuration
    logic [tffs_pkg::RES_W-1:0] grid_res_reg;

    // grid memory
    logic [WORD_W-1:0]           mem [tffs_pkg::STORE_DEPTH];
    logic [WORD_W-1:0]           mem_q;
    logic [tffs_pkg::ADDR_W-1:0] rd_addr;
    logic                        ld_ok;

    // captured position and cell setup
    logic [tffs_pkg::POS_W-1:0]     pos_reg [tffs_pkg::AXES];
    logic [tffs_pkg::R_W-1:0]       r_eff;
    logic [tffs_pkg::M_W-1:0]       m_val;
    logic signed [tffs_pkg::PE_W-1:0] pe [tffs_pkg::AXES];
    logic signed [tffs_pkg::T_W-1:0]  t_val [tffs_pkg::AXES];
    logic [tffs_pkg::AXES-1:0]      ax_inside;
    logic [tffs_pkg::R_W-1:0]       r_reg;
    logic [tffs_pkg::RR_W-1:0]      rr_reg;
    logic [tffs_pkg::IDX_W-1:0]     q_reg [tffs_pkg::AXES];
    logic [tffs_pkg::FRAC_BITS-1:0] f_reg [tffs_pkg::AXES];
    logic                           inside_reg;
    logic                           res_zero_reg;

    // corner issue
    logic [tffs_pkg::R_W-1:0] cc [tffs_pkg::AXES];
    logic [tffs_pkg::W_W-1:0] wsel [tffs_pkg::AXES];
    logic                     corner_ok;

    // pipeline
    logic                           v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [tffs_pkg::PW_W-1:0]      pxy1_reg;
    logic [tffs_pkg::W_W-1:0]       wz1_reg, wz2_reg;
    logic [tffs_pkg::W_W-1:0]       w1_2_reg;
    logic [tffs_pkg::PW_W-1:0]      pw3_reg;
    logic [tffs_pkg::W_W-1:0]       w4_reg;
    logic [tffs_pkg::PW_W-1:0]      pxy_rnd;
    logic [tffs_pkg::PW_W-1:0]      pw_rnd;
    logic signed [tffs_pkg::FORCE_W-1:0] data2_reg [tffs_pkg::AXES];
    logic signed [tffs_pkg::FORCE_W-1:0] data3_reg [tffs_pkg::AXES];
    logic signed [tffs_pkg::FORCE_W-1:0] data4_reg [tffs_pkg::AXES];
    logic signed [tffs_pkg::PROD_W-1:0]  prod5_reg [tffs_pkg::AXES];
    logic signed [tffs_pkg::ACC_W-1:0]   acc_reg [tffs_pkg::AXES];

    // result
    logic [tffs_pkg::ACC_W-1:0]   rsum [tffs_pkg::AXES];
    logic [tffs_pkg::FORCE_W-1:0] sat_val [tffs_pkg::AXES];
    logic signed [tffs_pkg::FORCE_W-1:0] out_reg [tffs_pkg::AXES];
    logic                         in_grid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_res_reg <= '0;
        end
        else if (cfg_we)
        begin
            grid_res_reg <= cfg_res;
        end
    end

    // grid memory, one write and one registered read per cycle
    assign ld_ok = (32'(entry_index) < tffs_pkg::STORE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && ld_ok)
        begin
            mem[tffs_pkg::ADDR_W'(entry_index)] <= {load_fz, load_fy, load_fx};
        end
        mem_q <= mem[rd_addr];
    end

    // cell index and fraction per axis
    always_comb
    begin
        if (32'(grid_res_reg) > tffs_pkg::MAX_GRID)
        begin
            r_eff = tffs_pkg::R_W'(tffs_pkg::MAX_GRID);
        end
        else
        begin
            r_eff = tffs_pkg::R_W'(grid_res_reg);
        end
        if (r_eff == tffs_pkg::R_W'(1))
        begin
            m_val = tffs_pkg::M_W'(4);
        end
        else
        begin
            m_val = tffs_pkg::M_W'(r_eff - 1'b1);
        end
        for (int a = 0; a < tffs_pkg::AXES; a++)
        begin
            pe[a]    = $signed({pos_reg[a][tffs_pkg::POS_W-1], pos_reg[a]})
                       + $signed(tffs_pkg::PE_W'(tffs_pkg::TWO_Q16));
            t_val[a] = tffs_pkg::T_W'(pe[a]) * tffs_pkg::T_W'($signed({1'b0, m_val}));
            ax_inside[a] = !t_val[a][tffs_pkg::T_W-1]
                           && (t_val[a][tffs_pkg::T_W-1:tffs_pkg::FRAC_BITS]
                               < tffs_pkg::Q_W'(r_eff));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
        end
        if (cmd.setup)
        begin
            r_reg        <= r_eff;
            rr_reg       <= tffs_pkg::RR_W'(r_eff * r_eff);
            inside_reg   <= &ax_inside;
            res_zero_reg <= (r_eff == '0);
            for (int a = 0; a < tffs_pkg::AXES; a++)
            begin
                q_reg[a] <= t_val[a][tffs_pkg::FRAC_BITS+tffs_pkg::IDX_W-1:tffs_pkg::FRAC_BITS];
                f_reg[a] <= t_val[a][tffs_pkg::FRAC_BITS-1:0];
            end
        end
    end

    assign sts.in_range = inside_reg;
    assign sts.res_zero = res_zero_reg;

    // corner coordinates, address and axis weights
    always_comb
    begin
        for (int a = 0; a < tffs_pkg::AXES; a++)
        begin
            cc[a]   = tffs_pkg::R_W'(q_reg[a]) + tffs_pkg::R_W'(cmd.corner[2-a]);
            wsel[a] = cmd.corner[2-a] ? {1'b0, f_reg[a]}
                                      : tffs_pkg::W_ONE - {1'b0, f_reg[a]};
        end
        corner_ok = (cc[0] < r_reg) && (cc[1] < r_reg) && (cc[2] < r_reg);
        rd_addr   = tffs_pkg::ADDR_W'(tffs_pkg::ADDR_W'(cc[0]) * tffs_pkg::ADDR_W'(rr_reg))
                  + tffs_pkg::ADDR_W'(tffs_pkg::ADDR_W'(cc[1]) * tffs_pkg::ADDR_W'(r_reg))
                  + tffs_pkg::ADDR_W'(cc[2]);
    end

    assign pxy_rnd = pxy1_reg + tffs_pkg::PW_W'(tffs_pkg::W_ONE >> 1);
    assign pw_rnd  = pw3_reg + tffs_pkg::PW_W'(tffs_pkg::W_ONE >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue && corner_ok;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pxy1_reg <= tffs_pkg::PW_W'(wsel[0]) * tffs_pkg::PW_W'(wsel[1]);
        wz1_reg  <= wsel[2];
        w1_2_reg <= pxy_rnd[tffs_pkg::FRAC_BITS+tffs_pkg::W_W-1:tffs_pkg::FRAC_BITS];
        wz2_reg  <= wz1_reg;
        pw3_reg  <= tffs_pkg::PW_W'(w1_2_reg) * tffs_pkg::PW_W'(wz2_reg);
        w4_reg   <= pw_rnd[tffs_pkg::FRAC_BITS+tffs_pkg::W_W-1:tffs_pkg::FRAC_BITS];
        for (int a = 0; a < tffs_pkg::AXES; a++)
        begin
            data2_reg[a] <= mem_q[a*tffs_pkg::FORCE_W +: tffs_pkg::FORCE_W];
            data3_reg[a] <= data2_reg[a];
            data4_reg[a] <= data3_reg[a];
            prod5_reg[a] <= tffs_pkg::PROD_W'(data4_reg[a])
                            * tffs_pkg::PROD_W'($signed({1'b0, w4_reg}));
            if (cmd.clear_acc)
            begin
                acc_reg[a] <= '0;
            end
            else if (v5_reg)
            begin
                acc_reg[a] <= acc_reg[a] + tffs_pkg::ACC_W'(prod5_reg[a]);
            end
        end
    end

    // round half up to q16.16 and saturate
    always_comb
    begin
        for (int a = 0; a < tffs_pkg::AXES; a++)
        begin
            rsum[a] = acc_reg[a] + tffs_pkg::ACC_W'(tffs_pkg::W_ONE >> 1);
            if ((&rsum[a][tffs_pkg::ACC_W-1:tffs_pkg::FRAC_BITS+tffs_pkg::FORCE_W-1])
                || !(|rsum[a][tffs_pkg::ACC_W-1:tffs_pkg::FRAC_BITS+tffs_pkg::FORCE_W-1]))
            begin
                sat_val[a] = rsum[a][tffs_pkg::FRAC_BITS+tffs_pkg::FORCE_W-1:tffs_pkg::FRAC_BITS];
            end
            else if (rsum[a][tffs_pkg::ACC_W-1])
            begin
                sat_val[a] = {1'b1, {(tffs_pkg::FORCE_W-1){1'b0}}};
            end
            else
            begin
                sat_val[a] = {1'b0, {(tffs_pkg::FORCE_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            in_grid_reg <= !cmd.out_zero;
            for (int a = 0; a < tffs_pkg::AXES; a++)
            begin
                out_reg[a] <= cmd.out_zero ? '0 : $signed(sat_val[a]);
            end
        end
    end

    assign out_fx  = out_reg[0];
    assign out_fy  = out_reg[1];
    assign out_fz  = out_reg[2];
    assign in_grid = in_grid_reg;

endmodule

// ===== design/trilinear_force_field_sampler_top.sv =====
// ----------------------------------------------------------------------------
// trilinear_force_field_sampler_top
// force grid store with trilinear sampling in fixed point
//
//   channel  role   payload                                      handshake
//   req      sink   kind, entry_index, load_f[xyz], pos_[xyz]    valid/ready
//   rsp      source out_f[xyz], in_grid                          valid/ready
//   cfg      sink   grid_resolution                              valid/ready
//
// a load item gives no result item
// a sample goes from acceptance to the result register through setup,
// decision, eight corner reads from the single grid memory read port, the
// weight and product pipeline drain, then the hand-off; outside the grid or
// at resolution zero it skips to the hand-off; the next item can be accepted
// in the cycle after the hand-off; reset clears the resolution register and
// control; grid contents stay undefined until loaded
// a held result stalls the next sample only at its final hand-off
// ----------------------------------------------------------------------------
module trilinear_force_field_sampler_top
(
    input  logic       clk,
    input  logic       rst_n,
    tffs_req_if.sink   req,
    tffs_rsp_if.source rsp,
    tffs_cfg_if.sink   cfg
);

    tffs_pkg::tffs_cmd_t cmd;
    tffs_pkg::tffs_sts_t sts;

    assign cfg.ready = 1'b1;

    tffs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_kind   (req.kind),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tffs_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg.valid),
        .cfg_res     (cfg.grid_resolution),
        .entry_index (req.entry_index),
        .load_fx     (req.load_fx),
        .load_fy     (req.load_fy),
        .load_fz     (req.load_fz),
        .pos_x       (req.pos_x),
        .pos_y       (req.pos_y),
        .pos_z       (req.pos_z),
        .cmd         (cmd),
        .sts         (sts),
        .out_fx      (rsp.out_fx),
        .out_fy      (rsp.out_fy),
        .out_fz      (rsp.out_fz),
        .in_grid     (rsp.in_grid)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the trilinear force field sampler: grid loads and
// position samples go in over the request channel, a local fixed point
// predictor works out each interpolated force, and every result item is
// compared field by field against the oldest prediction, under random idling
// on both channels and a sweep of resolution settings
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     SETTLE_CYCLES  = 20;
    localparam int     PHASE_ITEMS    = 170;
    localparam longint UNIT           = longint'(1) << tffs_pkg::FRAC_BITS;
    localparam longint HALF           = UNIT >>> 1;

    typedef struct packed {
        logic                                kind;
        logic [tffs_pkg::ENTRY_W-1:0]        entry;
        logic signed [tffs_pkg::FORCE_W-1:0] fx;
        logic signed [tffs_pkg::FORCE_W-1:0] fy;
        logic signed [tffs_pkg::FORCE_W-1:0] fz;
        logic signed [tffs_pkg::POS_W-1:0]   px;
        logic signed [tffs_pkg::POS_W-1:0]   py;
        logic signed [tffs_pkg::POS_W-1:0]   pz;
    } req_item_t;

    typedef struct packed {
        logic signed [tffs_pkg::FORCE_W-1:0] fx;
        logic signed [tffs_pkg::FORCE_W-1:0] fy;
        logic signed [tffs_pkg::FORCE_W-1:0] fz;
        logic                                in_grid;
    } force_t;

    logic clk;
    logic rst_n;

    tffs_req_if req_ch ();
    tffs_rsp_if rsp_ch ();
    tffs_cfg_if cfg_ch ();

    trilinear_force_field_sampler_top u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    logic signed [tffs_pkg::FORCE_W-1:0] grid_fx [tffs_pkg::STORE_DEPTH];
    logic signed [tffs_pkg::FORCE_W-1:0] grid_fy [tffs_pkg::STORE_DEPTH];
    logic signed [tffs_pkg::FORCE_W-1:0] grid_fz [tffs_pkg::STORE_DEPTH];
    bit                                  grid_loaded [tffs_pkg::STORE_DEPTH];
    int                                  res_eff;

    force_t pending_forces [$];
    int     mismatch_count;
    int     stall_cycles;
    int     sent_items;
    bit     gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic longint axis_scaled(input logic signed [tffs_pkg::POS_W-1:0] p);
        longint m;
        m = (res_eff > 1) ? longint'(res_eff - 1) : 4;
        return (longint'(p) + tffs_pkg::TWO_Q16) * m;
    endfunction

    function automatic bit inside_grid(input longint tx, input longint ty,
                                       input longint tz);
        if (res_eff == 0)
            return 1'b0;
        if (tx < 0 || ty < 0 || tz < 0)
            return 1'b0;
        if ((tx >>> tffs_pkg::FRAC_BITS) > res_eff - 1 ||
            (ty >>> tffs_pkg::FRAC_BITS) > res_eff - 1 ||
            (tz >>> tffs_pkg::FRAC_BITS) > res_eff - 1)
            return 1'b0;
        return 1'b1;
    endfunction

    // linear store index of a corner, or -1 when it lies past the top edge
    function automatic int corner_index(input longint tx, input longint ty,
                                        input longint tz, input int c);
        longint ci, cj, ck;
        ci = (tx >>> tffs_pkg::FRAC_BITS) + ((c >> 2) & 1);
        cj = (ty >>> tffs_pkg::FRAC_BITS) + ((c >> 1) & 1);
        ck = (tz >>> tffs_pkg::FRAC_BITS) + (c & 1);
        if (ci > res_eff - 1 || cj > res_eff - 1 || ck > res_eff - 1)
            return -1;
        return int'(ci * res_eff * res_eff + cj * res_eff + ck);
    endfunction

    function automatic logic signed [tffs_pkg::FORCE_W-1:0] to_q16(input longint acc);
        longint v;
        v = (acc + HALF) >>> tffs_pkg::FRAC_BITS;
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[tffs_pkg::FORCE_W-1:0];
    endfunction

    function automatic force_t predict_force(input logic signed [tffs_pkg::POS_W-1:0] px,
                                             input logic signed [tffs_pkg::POS_W-1:0] py,
                                             input logic signed [tffs_pkg::POS_W-1:0] pz);
        longint tx, ty, tz, wx, wy, wz, w;
        longint acc_x, acc_y, acc_z;
        int     idx;
        force_t r;
        r     = '0;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        tx    = axis_scaled(px);
        ty    = axis_scaled(py);
        tz    = axis_scaled(pz);
        if (!inside_grid(tx, ty, tz))
            return r;
        for (int c = 0; c < tffs_pkg::CORNERS; c++)
        begin
            idx = corner_index(tx, ty, tz, c);
            if (idx < 0)
                continue;
            wx = ((c & 4) != 0) ? (tx & (UNIT - 1)) : UNIT - (tx & (UNIT - 1));
            wy = ((c & 2) != 0) ? (ty & (UNIT - 1)) : UNIT - (ty & (UNIT - 1));
            wz = ((c & 1) != 0) ? (tz & (UNIT - 1)) : UNIT - (tz & (UNIT - 1));
            w  = (wx * wy + HALF) >>> tffs_pkg::FRAC_BITS;
            w  = (w * wz + HALF) >>> tffs_pkg::FRAC_BITS;
            acc_x += longint'(grid_fx[idx]) * w;
            acc_y += longint'(grid_fy[idx]) * w;
            acc_z += longint'(grid_fz[idx]) * w;
        end
        r.fx      = to_q16(acc_x);
        r.fy      = to_q16(acc_y);
        r.fz      = to_q16(acc_z);
        r.in_grid = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // random values
    // ------------------------------------------------------------------------
    function automatic logic signed [tffs_pkg::FORCE_W-1:0] rand_force();
        if ($urandom_range(99) < 15)
        begin
            case ($urandom_range(3))
                0:       return 32'sh7FFFFFFF;
                1:       return 32'sh80000000;
                2:       return 32'sh00000000;
                default: return 32'shFFFFFFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic signed [tffs_pkg::POS_W-1:0] rand_pos();
        int k;
        k = $urandom_range(99);
        if (k < 10)
            return tffs_pkg::POS_W'($urandom);
        if (k < 22)
        begin
            case ($urandom_range(5))
                0:       return -24'sd131072;
                1:       return 24'sd131072;
                2:       return 24'sd0;
                3:       return -24'sd131073;
                4:       return 24'sd131073;
                default: return 24'sd131071;
            endcase
        end
        return tffs_pkg::POS_W'(int'($urandom_range(280000)) - 140000);
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    task automatic send_item(input req_item_t it);
        if (gaps_on && $urandom_range(99) < 30)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_ch.kind        = it.kind;
        req_ch.entry_index = it.entry;
        req_ch.load_fx     = it.fx;
        req_ch.load_fy     = it.fy;
        req_ch.load_fz     = it.fz;
        req_ch.pos_x       = it.px;
        req_ch.pos_y       = it.py;
        req_ch.pos_z       = it.pz;
        req_ch.valid       = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent_items++;
        if (it.kind == tffs_pkg::KIND_LOAD)
        begin
            grid_fx[it.entry]     = it.fx;
            grid_fy[it.entry]     = it.fy;
            grid_fz[it.entry]     = it.fz;
            grid_loaded[it.entry] = 1'b1;
        end
        else
        begin
            pending_forces.push_back(predict_force(it.px, it.py, it.pz));
        end
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic load_entry(input int idx,
                              input logic signed [tffs_pkg::FORCE_W-1:0] fx,
                              input logic signed [tffs_pkg::FORCE_W-1:0] fy,
                              input logic signed [tffs_pkg::FORCE_W-1:0] fz);
        req_item_t it;
        it.kind  = tffs_pkg::KIND_LOAD;
        it.entry = idx[tffs_pkg::ENTRY_W-1:0];
        it.fx    = fx;
        it.fy    = fy;
        it.fz    = fz;
        it.px    = tffs_pkg::POS_W'($urandom);
        it.py    = tffs_pkg::POS_W'($urandom);
        it.pz    = tffs_pkg::POS_W'($urandom);
        send_item(it);
    endtask

    // corners that the sample will read are loaded first if still unwritten
    task automatic sample_point(input logic signed [tffs_pkg::POS_W-1:0] px,
                                input logic signed [tffs_pkg::POS_W-1:0] py,
                                input logic signed [tffs_pkg::POS_W-1:0] pz);
        req_item_t it;
        longint    tx, ty, tz;
        int        idx;
        tx = axis_scaled(px);
        ty = axis_scaled(py);
        tz = axis_scaled(pz);
        if (inside_grid(tx, ty, tz))
        begin
            for (int c = 0; c < tffs_pkg::CORNERS; c++)
            begin
                idx = corner_index(tx, ty, tz, c);
                if (idx >= 0 && !grid_loaded[idx])
                    load_entry(idx, rand_force(), rand_force(), rand_force());
            end
        end
        it.kind  = tffs_pkg::KIND_SAMPLE;
        it.entry = tffs_pkg::ENTRY_W'($urandom);
        it.fx    = $urandom;
        it.fy    = $urandom;
        it.fz    = $urandom;
        it.px    = px;
        it.py    = py;
        it.pz    = pz;
        send_item(it);
    endtask

    task automatic wait_for_results();
        while (pending_forces.size() != 0)
            @(negedge clk);
    endtask

    // only written once the block has drained
    task automatic set_resolution(input logic [tffs_pkg::RES_W-1:0] v);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_ch.grid_resolution = v;
        cfg_ch.valid           = 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        res_eff = (int'(v) > tffs_pkg::MAX_GRID) ? tffs_pkg::MAX_GRID : int'(v);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = !(gaps_on && $urandom_range(99) < 30);
        end
    end

    always @(posedge clk)
    begin
        force_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_forces.size() == 0)
            begin
                $error("unexpected result item: out_fx %0d out_fy %0d out_fz %0d in_grid %0b",
                       rsp_ch.out_fx, rsp_ch.out_fy, rsp_ch.out_fz, rsp_ch.in_grid);
                mismatch_count++;
            end
            else
            begin
                want = pending_forces.pop_front();
                if (rsp_ch.out_fx !== want.fx)
                begin
                    $error("out_fx: expected %0d, got %0d", want.fx, rsp_ch.out_fx);
                    mismatch_count++;
                end
                if (rsp_ch.out_fy !== want.fy)
                begin
                    $error("out_fy: expected %0d, got %0d", want.fy, rsp_ch.out_fy);
                    mismatch_count++;
                end
                if (rsp_ch.out_fz !== want.fz)
                begin
                    $error("out_fz: expected %0d, got %0d", want.fz, rsp_ch.out_fz);
                    mismatch_count++;
                end
                if (rsp_ch.in_grid !== want.in_grid)
                begin
                    $error("in_grid: expected %0b, got %0b", want.in_grid, rsp_ch.in_grid);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_disabled_after_reset();
        sample_point(24'sd0, 24'sd0, 24'sd0);
        sample_point(24'sh7FFFFF, -24'sd131072, 24'sh800000);
    endtask

    task automatic test_two_point_grid();
        set_resolution(5'd2);
        load_entry(0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000);
        load_entry(1, 32'sh80000000, 32'sh7FFFFFFF, 32'shFFFFFFFF);
        load_entry(2, 32'sh00000000, 32'shFFFFFFFF, 32'sh7FFFFFFF);
        load_entry(3, 32'shFFFFFFFF, 32'sh00010000, 32'sh80000000);
        load_entry(4, 32'sh00010000, 32'shFFFF0000, rand_force());
        load_entry(5, 32'shFFFF0000, rand_force(), 32'sh00010000);
        load_entry(6, rand_force(), 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        load_entry(7, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
        sample_point(24'sd0, 24'sd0, 24'sd0);
        sample_point(-24'sd131072, -24'sd131072, -24'sd131072);
        // top edge on every axis
        sample_point(24'sd131072, 24'sd131072, 24'sd131072);
        sample_point(24'sd131072, 24'sd0, -24'sd131072);
        sample_point(-24'sd43691, -24'sd43691, -24'sd43691);
        sample_point(-24'sd131073, 24'sd0, 24'sd0);
        sample_point(24'sd0, 24'sd0, 24'sd393216);
        sample_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        sample_point(24'sh800000, 24'sd0, 24'sd0);
    endtask

    task automatic test_single_point_grid();
        set_resolution(5'd1);
        sample_point(-24'sd131072, -24'sd131072, -24'sd131072);
        sample_point(-24'sd98304, -24'sd81920, -24'sd120000);
        sample_point(-24'sd65536, -24'sd131072, -24'sd131072);
    endtask

    task automatic test_oversized_resolution();
        set_resolution(5'd31);
        sample_point(24'sd0, 24'sd0, 24'sd0);
        sample_point(24'sd131072, 24'sd131072, 24'sd131072);
        sample_point(-24'sd131072, 24'sd70000, -24'sd5000);
        set_resolution(5'd17);
        sample_point(24'sd12345, -24'sd54321, 24'sd99999);
    endtask

    // each phase sends about PHASE_ITEMS items, corner loads included
    task automatic test_random_sweep();
        int res_list [10];
        int idx;
        int start;
        bit paused;
        res_list = '{3, 16, 4, 0, 8, 1, 15, 2, 5, 31};
        for (int ph = 0; ph < 10; ph++)
        begin
            set_resolution(res_list[ph][tffs_pkg::RES_W-1:0]);
            // one phase runs flat out on both channels
            gaps_on = (ph != 4);
            start   = sent_items;
            paused  = 1'b0;
            while (sent_items - start < PHASE_ITEMS)
            begin
                if (!paused && sent_items - start >= PHASE_ITEMS / 2)
                begin
                    wait_for_results();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 40)
                begin
                    if (res_eff == 0 || $urandom_range(1) == 0)
                        idx = $urandom_range(tffs_pkg::STORE_DEPTH - 1);
                    else
                        idx = $urandom_range(res_eff * res_eff * res_eff - 1);
                    load_entry(idx, rand_force(), rand_force(), rand_force());
                end
                else
                begin
                    sample_point(rand_pos(), rand_pos(), rand_pos());
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        mismatch_count         = 0;
        sent_items             = 0;
        gaps_on                = 1'b1;
        res_eff                = 0;
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.kind            = tffs_pkg::KIND_LOAD;
        req_ch.entry_index     = '0;
        req_ch.load_fx         = '0;
        req_ch.load_fy         = '0;
        req_ch.load_fz         = '0;
        req_ch.pos_x           = '0;
        req_ch.pos_y           = '0;
        req_ch.pos_z           = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.grid_resolution = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_disabled_after_reset();
        test_two_point_grid();
        test_single_point_grid();
        test_oversized_resolution();
        test_random_sweep();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== trilinear_force_field_sampler_top.f =====
design/tffs_pkg.sv
design/tffs_if.sv
design/tffs_ctrl.sv
design/tffs_dp.sv
design/trilinear_force_field_sampler_top.sv
tb/sv/tb_top.sv
